// ===== src/smf_pkg.sv =====
// Package for the seven-bit message framer with CRC-6.
// Holds the channel payload types, framing constants and the CRC byte step.
// No dependencies.
package smf_pkg;

    localparam int unsigned MaxResults = 4;

    localparam logic [7:0] CRC_INIT   = 8'hFC;
    localparam logic [7:0] CRC_POLY   = 8'h9C;
    localparam logic [7:0] MARK_BEGIN = 8'h80;
    localparam logic [7:0] MARK_END   = 8'hC0;
    localparam logic [2:0] PEND_FULL  = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [5:0] msg_type;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_item_t;

    // Framer state between items; acc holds pend valid bits, zeros above.
    typedef struct packed {
        logic [5:0] acc;
        logic [2:0] pend;
        logic [7:0] crc;
        logic       in_msg;
    } frame_state_t;

    // Everything one item produces: next state and its line bytes.
    typedef struct packed {
        frame_state_t                    nxt;
        logic [MaxResults-1:0][7:0]      bytes;
        logic [2:0]                      count;
    } frame_result_t;

    // Feed one byte through the left-aligned CRC-6, MSB first.
    function automatic logic [7:0] crc_feed_byte(input logic [7:0] crc,
                                                 input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== src/smf_frame_calc.sv =====
// Per-item framing logic: markers, 7-bit grouping, flush and CRC update.
// Purely combinational; depends on smf_pkg.
module smf_frame_calc (
    input  smf_pkg::frame_state_t  state,
    input  smf_pkg::in_item_t      item,
    output smf_pkg::frame_result_t result
);

    smf_pkg::frame_state_t st;
    logic [13:0] comb_bits;
    logic [6:0]  leftover;
    logic        two_groups;
    logic [7:0]  crc_new;
    logic [2:0]  n;

    always_comb begin
        // Start of a message begins from clean state.
        if (state.in_msg) begin
            st = state;
        end else begin
            st.acc    = '0;
            st.pend   = '0;
            st.crc    = smf_pkg::CRC_INIT;
            st.in_msg = 1'b0;
        end
    end

    assign crc_new    = smf_pkg::crc_feed_byte(st.crc, item.data_byte);
    assign comb_bits  = ({6'b0, item.data_byte} << st.pend) | {8'b0, st.acc};
    assign two_groups = (st.pend == smf_pkg::PEND_FULL);
    assign leftover   = comb_bits[13:7];

    always_comb begin
        result = '0;
        n      = '0;
        if (!state.in_msg) begin
            result.bytes[n[1:0]] = smf_pkg::MARK_BEGIN | {2'b0, item.msg_type};
            n = n + 3'd1;
        end
        result.bytes[n[1:0]] = {1'b0, comb_bits[6:0]};
        n = n + 3'd1;
        if (two_groups) begin
            result.bytes[n[1:0]] = {1'b0, leftover};
            n = n + 3'd1;
        end
        if (item.last_byte) begin
            if (!two_groups) begin
                result.bytes[n[1:0]] = {1'b0, leftover};
                n = n + 3'd1;
            end
            result.bytes[n[1:0]] = smf_pkg::MARK_END | {2'b0, crc_new[7:2]};
            n = n + 3'd1;
            // Return to idle after the end marker.
            result.nxt.acc    = '0;
            result.nxt.pend   = '0;
            result.nxt.crc    = smf_pkg::CRC_INIT;
            result.nxt.in_msg = 1'b0;
        end else begin
            result.nxt.acc    = two_groups ? 6'b0 : leftover[5:0];
            result.nxt.pend   = two_groups ? 3'd0 : st.pend + 3'd1;
            result.nxt.crc    = crc_new;
            result.nxt.in_msg = 1'b1;
        end
        result.count = n;
    end

endmodule

// ===== src/seven_bit_message_framer_crc6_unit.sv =====
// Top level of the seven-bit message framer with CRC-6.
// Holds framer state and the result queue; uses smf_pkg and smf_frame_calc.
//
//   channel | direction | ports                          | payload
//   s_      | in        | s_valid, s_ready, s_payload    | smf_pkg::in_item_t
//   m_      | out       | m_valid, m_ready, m_payload    | smf_pkg::out_item_t
//
// Each item gives 1 to 4 line bytes, loaded into a four-entry shift queue in
// the cycle it is accepted and drained one byte per cycle while m_ready is
// high; an item holds the queue until its results (mostly 1 or 2) are out.
// A new item is taken in the cycle the queue's last byte transfers.
// Reset (aresetn low, synchronous) empties the queue and returns to idle.
// A stalled m_ready holds the queue and, with it, the input side.
module seven_bit_message_framer_crc6_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  smf_pkg::in_item_t   s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output smf_pkg::out_item_t  m_payload
);

    smf_pkg::frame_state_t                      state_reg;
    smf_pkg::frame_result_t                     calc;
    logic [smf_pkg::MaxResults-1:0][7:0]        queue_reg;
    logic [2:0]                                 count_reg;
    logic [2:0]                                 count_next;
    logic                                       s_xfer;
    logic                                       m_xfer;

    smf_frame_calc u_calc (
        .state  (state_reg),
        .item   (s_payload),
        .result (calc)
    );

    assign m_valid            = (count_reg != 3'd0);
    assign m_xfer             = m_valid && m_ready;
    assign s_ready            = (count_reg == 3'd0) || ((count_reg == 3'd1) && m_ready);
    assign s_xfer             = s_valid && s_ready;
    assign m_payload.out_byte = queue_reg[0];
    assign m_payload.run_last = (count_reg == 3'd1);

    always_comb begin
        if (s_xfer) begin
            count_next = calc.count;
        end else if (m_xfer) begin
            count_next = count_reg - 3'd1;
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg        <= '0;
            state_reg.acc    <= '0;
            state_reg.pend   <= '0;
            state_reg.crc    <= smf_pkg::CRC_INIT;
            state_reg.in_msg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (s_xfer) begin
                state_reg <= calc.nxt;
            end
        end
    end

    // Load a fresh item's bytes, or advance the queue on a transfer.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            queue_reg <= calc.bytes;
        end else if (m_xfer) begin
            for (int i = 0; i < smf_pkg::MaxResults - 1; i++) begin
                queue_reg[i] <= queue_reg[i+1];
            end
        end
    end

endmodule

// ===== src/smf_checker.sv =====
// Port-level checks for the seven-bit message framer with CRC-6.
// Depends on smf_pkg; bound to seven_bit_message_framer_crc6_unit below.
module smf_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input smf_pkg::in_item_t   s_payload,
    input logic                m_valid,
    input logic                m_ready,
    input smf_pkg::out_item_t  m_payload
);

    // A stalled result holds its byte.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // Every accepted item gives at least one result.
    a_item_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted item gave no result");

    // No new item while more than one result of the last one remains.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.run_last |-> !s_ready)
        else $error("input taken while results still queued");

    // With nothing queued the input side is open.
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("idle block refuses input");

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

endmodule

bind seven_bit_message_framer_crc6_unit smf_checker u_smf_checker (.*);
